// ===== rtl/core/spmv_pkg.sv =====
// Shared types and constants for the CSR sparse matrix-vector multiply core.
// No dependencies; compiled first.
package spmv_pkg;

  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int ACC_W   = 64;
  localparam int FRAC_W  = 16;

  typedef logic [FUNC_W-1:0]          func_t;
  typedef logic [INDEX_W-1:0]         index_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // item function codes; the fourth code is ignored
  localparam func_t FUNC_LOAD  = 2'd0;
  localparam func_t FUNC_ENTRY = 2'd1;
  localparam func_t FUNC_EMPTY = 2'd2;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

// ===== rtl/core/spmv_if.sv =====
// Valid/ready stream interfaces for the item and result channels.
// Depends on spmv_pkg.
interface spmv_item_if;
  import spmv_pkg::*;

  logic   valid;
  logic   ready;
  func_t  func;
  index_t index;
  value_t value;
  value_t addend;
  logic   row_first;
  logic   row_last;

  modport source (output valid, func, index, value, addend, row_first, row_last,
                  input ready);
  modport sink   (input valid, func, index, value, addend, row_first, row_last,
                  output ready);
endinterface

interface spmv_result_if;
  import spmv_pkg::*;

  logic   valid;
  logic   ready;
  value_t row_value;
  logic   row_had_entries;

  modport source (output valid, row_value, row_had_entries, input ready);
  modport sink   (input valid, row_value, row_had_entries, output ready);
endinterface

// ===== rtl/core/spmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/csr_sparse_matrix_vector_multiply_core.sv =====
// CSR sparse matrix-vector multiply core: vector store, Q16.16 multiply, Q32.32 accumulate.
// Depends on spmv_pkg, spmv_if (item/result interfaces) and spmv_ram.
// The item ending a row passes stages 1, 2, 3 and the output register before its result is valid.
// Throughput: one item per cycle; the vector RAM's single read port and the one
// multiply-accumulate per cycle set that rate. Stalls only under output backpressure.
// Reset clears pipeline valids, the row accumulator and add_mode; the vector store is not cleared.
module csr_sparse_matrix_vector_multiply_core #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  spmv_item_if.sink          item,
  spmv_result_if.source      result
);
  import spmv_pkg::*;

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic add_mode;

  // stage enables, back to front
  logic en_out, en3, en2, en1, accept;

  // stage 1: RAM read in flight
  logic   s1_valid;
  func_t  s1_func;
  logic   s1_inb;
  value_t s1_value;
  value_t s1_addend;
  logic   s1_first;
  logic   s1_last;
  logic [VALUE_W-1:0] ram_rdata;

  // stage 2: product
  logic   s2_valid;
  func_t  s2_func;
  acc_t   s2_prod;
  value_t s2_addend;
  logic   s2_first;
  logic   s2_last;

  // stage 3: finished row sum
  logic   s3_valid;
  acc_t   s3_sum;
  logic   s3_had;

  logic   out_valid;
  value_t out_value;
  logic   out_had;

  acc_t   acc;

  logic            item_inb;
  acc_t            mul;
  acc_t            addend_q32;
  acc_t            base;
  logic [ACC_W:0]  sum_wide;
  acc_t            sum_sat;
  logic            s2_ends_row;
  logic            s2_empty;
  logic [ACC_W-FRAC_W-1:0] q;
  value_t          finish;

  assign en_out = !out_valid || result.ready;
  assign en3    = !s3_valid || en_out;
  assign en2    = !s2_valid || en3;
  assign en1    = !s1_valid || en2;
  assign item.ready = en1;
  assign accept = item.valid && en1;

  assign item_inb = 32'(item.index) < 32'(VECTOR_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      add_mode <= 1'b0;
    end else if (cfg_we) begin
      add_mode <= cfg_wdata;
    end
  end

  // loads write at their own transfer edge, so the next item already reads the new data
  spmv_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vector_ram (
    .clk   (clk),
    .we    (accept && item.func == FUNC_LOAD && item_inb),
    .waddr (AW'(item.index)),
    .wdata (item.value),
    .re    (accept),
    .raddr (AW'(item.index)),
    .rdata (ram_rdata)
  );

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func   <= item.func;
      s1_inb    <= item_inb;
      s1_value  <= item.value;
      s1_addend <= item.addend;
      s1_first  <= item.row_first;
      s1_last   <= item.row_last;
    end
  end

  // stage 2: exact Q16.16 x Q16.16 -> Q32.32
  assign mul = acc_t'(s1_value) * acc_t'($signed(ram_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && en2) begin
      s2_func   <= s1_func;
      s2_prod   <= s1_inb ? mul : '0;
      s2_addend <= s1_addend;
      s2_first  <= s1_first;
      s2_last   <= s1_last;
    end
  end

  // stage 2 -> 3: saturating accumulate
  assign addend_q32 = {{(ACC_W-VALUE_W-FRAC_W){s2_addend[VALUE_W-1]}}, s2_addend,
                       {FRAC_W{1'b0}}};
  assign base       = s2_first ? (add_mode ? addend_q32 : '0) : acc;
  assign sum_wide   = {base[ACC_W-1], base} + {s2_prod[ACC_W-1], s2_prod};

  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  assign s2_ends_row = s2_func == FUNC_ENTRY && s2_last;
  assign s2_empty    = s2_func == FUNC_EMPTY;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_valid && en3 && s2_func == FUNC_ENTRY) begin
      acc <= s2_last ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid && (s2_ends_row || s2_empty);
    end
  end

  // empty row: addend in Q32.32 floors back to itself on the way out
  always_ff @(posedge clk) begin
    if (s2_valid && en3) begin
      s3_sum <= s2_empty ? (add_mode ? addend_q32 : '0) : sum_sat;
      s3_had <= !s2_empty;
    end
  end

  // stage 3: floor to Q16.16 and saturate
  assign q = s3_sum[ACC_W-1:FRAC_W];

  always_comb begin
    if ((&q[ACC_W-FRAC_W-1:VALUE_W-1]) || !(|q[ACC_W-FRAC_W-1:VALUE_W-1])) begin
      finish = q[VALUE_W-1:0];
    end else begin
      finish = q[ACC_W-FRAC_W-1] ? VALUE_MIN : VALUE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && en_out) begin
      out_value <= finish;
      out_had   <= s3_had;
    end
  end

  assign result.valid           = out_valid;
  assign result.row_value       = out_value;
  assign result.row_had_entries = out_had;

  // back-pressure only originates at the output
  a_ready_low_means_stall: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> result.valid && !result.ready)
    else $error("input stalled without output backpressure");

  a_acc_clear_at_row_end: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && en3 && s2_ends_row) |=> acc == '0)
    else $error("accumulator not cleared after row end");

  a_result_from_stage3: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !$past(result.valid)) |-> $past(s3_valid))
    else $error("result appeared without a finished row");

  // only check on the cycle stage 3 was loaded; a held entry says nothing about stage 2
  a_empty_row_flag: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_had && $past(en3)) |-> $past(s2_empty))
    else $error("empty-row flag without an empty-row item");

endmodule

// ===== tb/sv/csr_sparse_matrix_vector_multiply_core_tb.sv =====
// Self-checking testbench for csr_sparse_matrix_vector_multiply_core.
// Row-sum scoreboard predicts each result; driver/receiver tasks add random idle.
// Depends on spmv_pkg, spmv_if and the core RTL.
`timescale 1ns / 100ps

import spmv_pkg::*;

typedef struct packed {
  value_t row_value;
  logic   had_entries;
} row_result_t;

class row_sum_scoreboard;
  localparam int PRINT_CAP = 40;

  value_t      vec_mem [1024];
  acc_t        row_sum_acc;
  bit          add_mode;
  row_result_t pending_row_sums[$];
  int          mismatches;

  function new();
    row_sum_acc = '0;
    add_mode    = 1'b0;
    mismatches  = 0;
  endfunction

  function acc_t saturating_add(acc_t a, acc_t b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(s[ACC_W-1:0]);
  endfunction

  // Q32.32 -> Q16.16: floor shift, then clamp to 32 bits
  function value_t floor_to_q16(acc_t acc);
    acc_t q;
    q = acc >>> FRAC_W;
    if (q > acc_t'(VALUE_MAX)) return VALUE_MAX;
    if (q < acc_t'(VALUE_MIN)) return VALUE_MIN;
    return value_t'(q[VALUE_W-1:0]);
  endfunction

  function void note_item(func_t func, index_t index, value_t value, value_t addend,
                          logic row_first, logic row_last);
    acc_t        elem;
    row_result_t row;
    case (func)
      FUNC_LOAD: begin
        vec_mem[index] = value;
      end
      FUNC_ENTRY: begin
        elem = acc_t'(vec_mem[index]);
        if (row_first) begin
          row_sum_acc = add_mode ? (acc_t'(addend) <<< FRAC_W) : '0;
        end
        row_sum_acc = saturating_add(row_sum_acc, acc_t'(value) * elem);
        if (row_last) begin
          row.row_value   = floor_to_q16(row_sum_acc);
          row.had_entries = 1'b1;
          pending_row_sums.push_back(row);
          row_sum_acc = '0;
        end
      end
      FUNC_EMPTY: begin
        row.row_value   = add_mode ? addend : '0;
        row.had_entries = 1'b0;
        pending_row_sums.push_back(row);
      end
      default: ;
    endcase
  endfunction

  function void check_row(value_t row_value, logic had_entries);
    row_result_t row;
    if (pending_row_sums.size() == 0) begin
      if (mismatches < PRINT_CAP)
        $display("%0t: unexpected result: expected none, got row_value %0d had_entries %0b",
                 $time, row_value, had_entries);
      mismatches++;
      return;
    end
    row = pending_row_sums.pop_front();
    if (row_value !== row.row_value) begin
      if (mismatches < PRINT_CAP)
        $display("%0t: row_value: expected %0d, got %0d", $time, row.row_value, row_value);
      mismatches++;
    end
    if (had_entries !== row.had_entries) begin
      if (mismatches < PRINT_CAP)
        $display("%0t: row_had_entries: expected %0b, got %0b",
                 $time, row.had_entries, had_entries);
      mismatches++;
    end
  endfunction
endclass

module csr_sparse_matrix_vector_multiply_core_tb;

  localparam func_t FUNC_UNUSED    = 2'd3;
  localparam int    MAX_IDLE       = 14;
  localparam int    SETTLE_CYCLES  = 8;
  localparam int    CYCLE_LIMIT    = 400000;
  localparam int    NUM_PHASES     = 6;
  localparam int    PHASE_ITEMS    = 285;
  localparam value_t ONE_Q16       = 32'sh0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_wdata;

  spmv_item_if   item_bus ();
  spmv_result_if result_bus ();

  row_sum_scoreboard sb;

  bit     idle_on = 1'b1;
  int     counted_items = 0;
  int     cycle_count = 0;
  bit     col_loaded [1024];
  index_t loaded_cols[$];

  csr_sparse_matrix_vector_multiply_core #(
    .VECTOR_DEPTH(1024)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_bus),
    .result    (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // monitors: sample pre-edge values at every rising edge
  always @(posedge clk) begin
    if (!rst && item_bus.valid && item_bus.ready)
      sb.note_item(item_bus.func, item_bus.index, item_bus.value, item_bus.addend,
                   item_bus.row_first, item_bus.row_last);
    if (!rst && result_bus.valid && result_bus.ready)
      sb.check_row(result_bus.row_value, result_bus.row_had_entries);
  end

  // result receiver: random stall before each transfer
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
    end
  end

  function automatic value_t rand_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return -ONE_Q16;
      4, 5, 6: return value_t'(int'($urandom_range(0, 524288)) - 262144);
      default: return value_t'($urandom());
    endcase
  endfunction

  function automatic index_t pick_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  task automatic send_item(input func_t func, input index_t index, input value_t value,
                           input value_t addend, input logic row_first, input logic row_last);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.func      <= func;
    item_bus.index     <= index;
    item_bus.value     <= value;
    item_bus.addend    <= addend;
    item_bus.row_first <= row_first;
    item_bus.row_last  <= row_last;
    do @(posedge clk); while (!item_bus.ready);
    if (func != FUNC_UNUSED) counted_items++;
  endtask

  task automatic send_load(input index_t index, input value_t value);
    if (!col_loaded[index]) begin
      col_loaded[index] = 1'b1;
      loaded_cols.push_back(index);
    end
    send_item(FUNC_LOAD, index, value, rand_value(), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_entry(input index_t col, input value_t value, input value_t addend,
                            input logic row_first, input logic row_last);
    send_item(FUNC_ENTRY, col, value, addend, row_first, row_last);
  endtask

  task automatic send_empty(input value_t addend);
    send_item(FUNC_EMPTY, index_t'($urandom_range(0, 1023)), rand_value(), addend,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_ignored();
    send_item(FUNC_UNUSED, index_t'($urandom_range(0, 1023)), rand_value(), rand_value(),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_row(input int len);
    for (int i = 0; i < len; i++)
      send_entry(pick_col(), rand_value(), rand_value(), i == 0, i == len - 1);
  endtask

  // stop sending and wait out every outstanding row result
  task automatic drain();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_row_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_add_mode(input bit mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.add_mode = mode;
  endtask

  initial begin
    int pick;
    int len;
    sb = new();
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    item_bus.valid      = 1'b0;
    item_bus.func       = FUNC_LOAD;
    item_bus.index      = '0;
    item_bus.value      = '0;
    item_bus.addend     = '0;
    item_bus.row_first  = 1'b0;
    item_bus.row_last   = 1'b0;
    result_bus.ready    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed, add_mode at reset value (row sums start at zero)
    send_load(10'd0, VALUE_MAX);
    send_load(10'd1023, VALUE_MIN);
    send_load(10'd512, ONE_Q16);
    send_load(10'd1, -32'sd1);
    send_load(10'd2, '0);
    send_ignored();
    send_entry(10'd512, 32'sh0001_8000, VALUE_MAX, 1'b1, 1'b1);
    // two max products overflow the accumulator high, third stays clamped
    send_entry(10'd1023, VALUE_MIN, '0, 1'b1, 1'b0);
    send_entry(10'd1023, VALUE_MIN, '0, 1'b0, 1'b0);
    send_entry(10'd1023, VALUE_MIN, '0, 1'b0, 1'b1);
    send_entry(10'd1023, VALUE_MAX, '0, 1'b1, 1'b0);
    send_entry(10'd1023, VALUE_MAX, '0, 1'b0, 1'b0);
    send_entry(10'd1023, VALUE_MAX, '0, 1'b0, 1'b1);
    // row without a first mark accumulates from the cleared sum
    send_entry(10'd1, ONE_Q16, '0, 1'b0, 1'b0);
    send_entry(10'd2, VALUE_MAX, '0, 1'b0, 1'b1);
    // -1 LSB in Q32.32 floors to -1 LSB in Q16.16
    send_entry(10'd1, 32'sd1, '0, 1'b1, 1'b1);
    send_empty(VALUE_MAX);
    drain();

    write_add_mode(1'b1);
    send_entry(10'd512, ONE_Q16, VALUE_MAX, 1'b1, 1'b1);
    send_empty(VALUE_MIN);
    send_entry(10'd512, ONE_Q16, -32'sd5, 1'b1, 1'b0);
    send_entry(10'd0, 32'sd3, VALUE_MAX, 1'b0, 1'b1);
    // a first mark mid-row restarts the sum
    send_entry(10'd512, VALUE_MAX, ONE_Q16, 1'b1, 1'b0);
    send_entry(10'd512, -ONE_Q16, VALUE_MIN, 1'b1, 1'b1);
    drain();

    // random phases
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0)      write_add_mode(1'b0);
      else if (phase == 1) write_add_mode(1'b1);
      else                 write_add_mode(1'($urandom_range(0, 1)));
      idle_on = (phase == 3) ? 1'b0 : (phase == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (phase == 0)
        for (int i = 0; i < 40; i++)
          send_load(index_t'($urandom_range(0, 1023)), rand_value());
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_load(index_t'($urandom_range(0, 1023)), rand_value());
        end else if (pick < 80) begin
          len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 12);
          send_row(len);
        end else if (pick < 88) begin
          send_empty(rand_value());
        end else if (pick < 94) begin
          // broken sequence: random row marks
          send_entry(pick_col(), rand_value(), rand_value(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 98) begin
          send_ignored();
        end else begin
          drain();
        end
      end
      drain();
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_row_sums.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
